// ----- sv/bitmap_page_allocator_core_macros.svh -----
// Assertion macros used by the bitmap page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/bpa_pkg.sv -----
// Types, codes and constants of the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES_DEF = 1024;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int COUNT_W       = 11;
  localparam int ADDR_W        = 32;
  localparam int BASE_W        = 20;
  localparam int CFG_DATA_W    = 20;
  localparam int LANES         = 8;
  localparam int LANE_SHIFT    = 3;
  localparam int CHK_W         = 22;

  localparam logic [COUNT_W-1:0] POOL_PAGES_RST = 11'd1024;
  localparam logic [BASE_W-1:0]  POOL_BASE_RST  = 20'd256;

  typedef enum logic [2:0] {
    ST_ALLOCATED    = 3'd0,
    ST_FREED        = 3'd1,
    ST_ZERO_COUNT   = 3'd2,
    ST_NO_MEMORY    = 3'd3,
    ST_FREE_IGNORED = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic {
    CFG_POOL_PAGES     = 1'b0,
    CFG_POOL_BASE_PAGE = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FREE_END,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [COUNT_W-1:0] run_pages;
    logic [ADDR_W-1:0]  address;
    logic               zero_fill;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] page_address;
    logic              clear_request;
  } rsp_t;

endpackage

// ----- sv/bpa_map_ram.sv -----
// Page map memory: one row of page bits per address, registered read.
module bpa_map_ram
  import bpa_pkg::*;
#(
  parameter int ROWS  = 128,
  parameter int ROW_W = 7
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [ROW_W-1:0] wr_row_i,
  input  logic [LANES-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [ROW_W-1:0] rd_row_i,
  output logic [LANES-1:0] rd_data_o
);

  logic [LANES-1:0] mem [ROWS];
  logic [LANES-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/bitmap_page_allocator_core.sv -----
// Top level of the bitmap first-fit page allocator.
//
// Channel   Direction  Handshake                       Payload
// command   in         start high while busy is low    cmd_i (cmd_t)
// result    out        result_valid_o for one cycle    result_o (rsp_t)
// config    in         cfg_valid_i and cfg_ready_o     cfg_index_i, cfg_data_i
//
// After reset the map is cleared one row of eight pages per cycle, every row in turn,
// with busy high. An allocate reads map rows in order through the single read port
// until a long enough free run is found, then does a read-modify-write of each marked
// row; a free checks the range, then does a read-modify-write of each cleared row.
// Refused requests end without writing the map. The result is shown for one cycle only, since
// the receiver cannot stall; busy drops in that cycle, so the next command can be taken.
`include "bitmap_page_allocator_core_macros.svh"
module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd_i,
  output logic                  result_valid_o,
  output rsp_t                  result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_index_e            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ROWS   = (MAX_PAGES + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ISS_W  = $clog2(ROWS + 1);
  localparam int PIDX_W = $clog2(MAX_PAGES + 1);
  localparam int N_W    = ((PIDX_W > COUNT_W) ? PIDX_W : COUNT_W) + 1;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [COUNT_W-1:0] pool_pages_q, pool_pages_d;
  logic [BASE_W-1:0]  pool_base_q, pool_base_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ISS_W-1:0]   issue_q, issue_d;
  logic [ROW_W-1:0]   drow_q, drow_d;
  logic               dval_q, dval_d;
  logic [COUNT_W-1:0] run_q, run_d;
  logic [N_W-1:0]     lo_q, lo_d;
  logic [N_W-1:0]     hi_q, hi_d;
  logic               set_q, set_d;
  logic               resv_q, resv_d;
  rsp_t               res_q, res_d;

  logic               mem_we;
  logic [ROW_W-1:0]   mem_wrow;
  logic [LANES-1:0]   mem_wdata;
  logic               mem_re;
  logic [ROW_W-1:0]   mem_rrow;
  logic [LANES-1:0]   mem_rdata;

  logic [N_W-1:0]     npages;
  logic [N_W-1:0]     pp_w;
  logic [N_W-1:0]     count_n;
  logic               count_zero;
  logic               count_big;
  logic               found_v;
  logic [N_W-1:0]     end_v;
  logic [COUNT_W-1:0] run_v;
  logic [N_W-1:0]     idx_v;
  logic [N_W-1:0]     alloc_lo;
  logic               scan_last;
  logic               issue_ok;
  logic [CHK_W-1:0]   page_v;
  logic [CHK_W-1:0]   base_v;
  logic [CHK_W-1:0]   lim_v;
  logic               out_of_pool;
  logic [N_W:0]       free_sum;
  logic               free_over;
  logic [LANES-1:0]   mask;
  logic [N_W-1:0]     mpage;
  logic               mark_last;
  logic               clear_last;
  logic [CHK_W-1:0]   addr_sum;

  bpa_map_ram #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_row_i  (mem_wrow),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_row_i  (mem_rrow),
    .rd_data_o (mem_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = resv_q;
  assign result_o       = res_q;

  always_comb begin
    pool_pages_d = pool_pages_q;
    pool_base_d  = pool_base_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POOL_PAGES:     pool_pages_d = cfg_data_i[COUNT_W-1:0];
        CFG_POOL_BASE_PAGE: pool_base_d  = cfg_data_i[BASE_W-1:0];
        default:            pool_pages_d = pool_pages_q;
      endcase
    end
  end

  always_comb begin
    pp_w       = N_W'(pool_pages_q);
    npages     = (pp_w > N_W'(MAX_PAGES)) ? N_W'(MAX_PAGES) : pp_w;
    count_n    = N_W'(cmd_q.run_pages);
    count_zero = (cmd_q.run_pages == '0);
    count_big  = (count_n > npages);

    run_v   = run_q;
    found_v = 1'b0;
    end_v   = '0;
    for (int k = 0; k < LANES; k++) begin
      idx_v = N_W'({drow_q, LANE_SHIFT'(k)});
      if (!found_v && (idx_v < npages)) begin
        if (mem_rdata[k]) begin
          run_v = '0;
        end else begin
          run_v = run_v + 1'b1;
        end
        if (run_v == cmd_q.run_pages) begin
          found_v = 1'b1;
          end_v   = idx_v;
        end
      end
    end
    alloc_lo  = end_v + N_W'(1) - count_n;
    scan_last = (N_W'({drow_q, {LANE_SHIFT{1'b0}}}) + N_W'(LANES)) >= npages;
    issue_ok  = N_W'({issue_q, {LANE_SHIFT{1'b0}}}) < npages;

    page_v      = CHK_W'(cmd_q.address[ADDR_W-1:PAGE_SHIFT]);
    base_v      = CHK_W'(pool_base_q);
    lim_v       = base_v + CHK_W'(npages);
    out_of_pool = (page_v < base_v) || (page_v >= lim_v);
    free_sum    = (N_W+1)'(lo_q) + (N_W+1)'(cmd_q.run_pages);
    free_over   = free_sum > (N_W+1)'(npages);

    for (int k = 0; k < LANES; k++) begin
      mpage   = N_W'({row_q, LANE_SHIFT'(k)});
      mask[k] = (mpage >= lo_q) && (mpage <= hi_q);
    end
    mark_last  = (row_q == hi_q[LANE_SHIFT +: ROW_W]);
    clear_last = (row_q == ROW_W'(ROWS - 1));
    addr_sum   = base_v + CHK_W'(lo_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_q.func == FUNC_ALLOC) begin
          state_d = (count_zero || count_big) ? S_IDLE : S_SCAN;
        end else begin
          state_d = out_of_pool ? S_IDLE : S_FREE_END;
        end
      end
      S_FREE_END: begin
        state_d = (free_over || count_zero) ? S_IDLE : S_MARK_RD;
      end
      S_SCAN: begin
        if (dval_q && found_v) begin
          state_d = S_MARK_RD;
        end else if (dval_q && scan_last) begin
          state_d = S_IDLE;
        end
      end
      S_MARK_RD: state_d = S_MARK_WR;
      S_MARK_WR: begin
        state_d = mark_last ? S_IDLE : S_MARK_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    row_d     = row_q;
    issue_d   = issue_q;
    drow_d    = drow_q;
    dval_d    = dval_q;
    run_d     = run_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    set_d     = set_q;
    resv_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wrow  = row_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_rrow  = row_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        row_d  = row_q + 1'b1;
      end
      S_IDLE: begin
        if (start) cmd_d = cmd_i;
      end
      S_CHECK: begin
        if (cmd_q.func == FUNC_ALLOC) begin
          if (count_zero) begin
            resv_d = 1'b1;
            res_d  = '{status: ST_ZERO_COUNT, page_address: '0, clear_request: 1'b0};
          end else if (count_big) begin
            resv_d = 1'b1;
            res_d  = '{status: ST_NO_MEMORY, page_address: '0, clear_request: 1'b0};
          end else begin
            issue_d = '0;
            dval_d  = 1'b0;
            run_d   = '0;
          end
        end else if (out_of_pool) begin
          resv_d = 1'b1;
          res_d  = '{status: ST_FREE_IGNORED, page_address: '0, clear_request: 1'b0};
        end else begin
          lo_d = N_W'(page_v - base_v);
        end
      end
      S_FREE_END: begin
        if (free_over) begin
          resv_d = 1'b1;
          res_d  = '{status: ST_FREE_IGNORED, page_address: '0, clear_request: 1'b0};
        end else if (count_zero) begin
          resv_d = 1'b1;
          res_d  = '{status: ST_FREED, page_address: '0, clear_request: 1'b0};
        end else begin
          hi_d  = N_W'(free_sum - 1'b1);
          row_d = lo_q[LANE_SHIFT +: ROW_W];
          set_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue_ok) begin
          mem_re   = 1'b1;
          mem_rrow = issue_q[ROW_W-1:0];
          issue_d  = issue_q + 1'b1;
          drow_d   = issue_q[ROW_W-1:0];
          dval_d   = 1'b1;
        end else begin
          dval_d = 1'b0;
        end
        if (dval_q) begin
          run_d = run_v;
          if (found_v) begin
            hi_d  = end_v;
            lo_d  = alloc_lo;
            row_d = alloc_lo[LANE_SHIFT +: ROW_W];
            set_d = 1'b1;
          end else if (scan_last) begin
            resv_d = 1'b1;
            res_d  = '{status: ST_NO_MEMORY, page_address: '0, clear_request: 1'b0};
          end
        end
      end
      S_MARK_RD: begin
        mem_re = 1'b1;
      end
      S_MARK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = set_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
        if (mark_last) begin
          resv_d = 1'b1;
          if (set_q) begin
            res_d = '{status: ST_ALLOCATED,
                      page_address: ADDR_W'({addr_sum, {PAGE_SHIFT{1'b0}}}),
                      clear_request: cmd_q.zero_fill};
          end else begin
            res_d = '{status: ST_FREED, page_address: '0, clear_request: 1'b0};
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      default: resv_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      pool_pages_q <= POOL_PAGES_RST;
      pool_base_q  <= POOL_BASE_RST;
      row_q        <= '0;
      issue_q      <= '0;
      dval_q       <= 1'b0;
      resv_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      pool_pages_q <= pool_pages_d;
      pool_base_q  <= pool_base_d;
      row_q        <= row_d;
      issue_q      <= issue_d;
      dval_q       <= dval_d;
      resv_q       <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    drow_q <= drow_d;
    run_q  <= run_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    set_q  <= set_d;
    res_q  <= res_d;
  end

  `BPA_ASSERT(a_result_after_busy, result_valid_o |-> $past(busy), "Result without a request")
  `BPA_ASSERT_NEXT(a_single_result, result_valid_o, !result_valid_o, "Result held too long")
  `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted request did not start")
  `BPA_ASSERT(a_map_write_busy, mem_we |-> busy, "Map written while idle")
  `BPA_ASSERT(a_clean_refusal,
    result_valid_o && result_o.status != ST_ALLOCATED |->
    result_o.page_address == '0 && !result_o.clear_request,
    "Refused or free result carries an address")

endmodule

// ----- sim/bitmap_page_allocator_core_tb.sv -----
// Self-checking testbench for the bitmap first-fit page allocator core.
`timescale 1ns / 1ps

import bpa_pkg::*;

typedef struct {
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] count;
} page_run_t;

class page_alloc_scoreboard;
  bit          taken[MAX_PAGES_DEF];
  int unsigned pool_pages;
  int unsigned pool_base;
  rsp_t        pending[$];
  page_run_t   live[$];
  int unsigned status_seen[5];
  int unsigned mismatches;
  int unsigned commands;
  int unsigned cfg_writes;

  function new();
    foreach (taken[i]) taken[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    pool_pages = POOL_PAGES_RST;
    pool_base  = POOL_BASE_RST;
    mismatches = 0;
    commands   = 0;
    cfg_writes = 0;
  endfunction

  function int unsigned active_pages();
    return (pool_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : pool_pages;
  endfunction

  function void write_reg(cfg_index_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_writes++;
    if (idx == CFG_POOL_PAGES) pool_pages = data[COUNT_W-1:0];
    else pool_base = data[BASE_W-1:0];
  endfunction

  // Computes the response of an accepted command and updates the page map.
  function void note_command(cmd_t c);
    rsp_t            r;
    int unsigned     npages;
    int unsigned     run;
    int unsigned     first;
    int unsigned     page;
    bit              found;
    longint unsigned addr64;
    r.status        = ST_ALLOCATED;
    r.page_address  = '0;
    r.clear_request = 1'b0;
    npages = active_pages();
    commands++;
    if (c.func == FUNC_ALLOC) begin
      if (c.run_pages == 0) begin
        r.status = ST_ZERO_COUNT;
      end else begin
        found = 1'b0;
        run   = 0;
        first = 0;
        if (c.run_pages <= npages) begin
          for (int unsigned i = 0; i < npages && !found; i++) begin
            run = taken[i] ? 0 : run + 1;
            if (run == c.run_pages) begin
              found = 1'b1;
              first = i + 1 - run;
            end
          end
        end
        if (!found) begin
          r.status = ST_NO_MEMORY;
        end else begin
          for (int unsigned i = first; i < first + c.run_pages; i++) taken[i] = 1'b1;
          addr64 = (64'(pool_base) + 64'(first)) * 64'(PAGE_BYTES);
          r.page_address  = addr64[ADDR_W-1:0];
          r.clear_request = c.zero_fill;
          live.push_back('{addr: r.page_address, count: c.run_pages});
        end
      end
    end else begin
      page = c.address >> PAGE_SHIFT;
      if (page < pool_base || page >= pool_base + npages ||
          (page - pool_base) + c.run_pages > npages) begin
        r.status = ST_FREE_IGNORED;
      end else begin
        first = page - pool_base;
        for (int unsigned i = first; i < first + c.run_pages; i++) taken[i] = 1'b0;
        r.status = ST_FREED;
      end
    end
    status_seen[int'(r.status)]++;
    pending.push_back(r);
  endfunction

  function void check_result(rsp_t got);
    rsp_t want;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing outstanding, status %0d address %h clear %b",
               $time, got.status, got.page_address, got.clear_request);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.page_address !== want.page_address) begin
      $display("%0t: page_address expected %h actual %h",
               $time, want.page_address, got.page_address);
      mismatches++;
    end
    if (got.clear_request !== want.clear_request) begin
      $display("%0t: clear_request expected %b actual %b",
               $time, want.clear_request, got.clear_request);
      mismatches++;
    end
  endfunction
endclass

module bitmap_page_allocator_core_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int NUM_SEGS    = 6;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  cmd_t                  cmd_i       = '0;
  logic                  result_valid_o;
  rsp_t                  result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_index_e            cfg_index_i = CFG_POOL_PAGES;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  page_alloc_scoreboard sb;
  int unsigned          stall_cycles = 0;

  bitmap_page_allocator_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.note_command(cmd_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (result_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(func_e f, int unsigned cnt, logic [ADDR_W-1:0] a,
                                    bit zf);
    cmd_t c;
    c.func      = f;
    c.run_pages = cnt[COUNT_W-1:0];
    c.address   = a;
    c.zero_fill = zf;
    return c;
  endfunction

  task automatic send_command(cmd_t c, int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_reg_idle(cfg_index_e idx, logic [CFG_DATA_W-1:0] data);
    do @(posedge clk_i); while (sb.pending.size() != 0 || busy);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic release_pool(int unsigned gap_pct);
    send_command(make_cmd(FUNC_FREE, sb.active_pages(), ADDR_W'(sb.pool_base) << PAGE_SHIFT,
                          1'($urandom_range(1))), gap_pct);
    sb.live.delete();
  endtask

  function automatic cmd_t random_cmd();
    cmd_t          c;
    int unsigned   pick;
    int unsigned   idx;
    int unsigned   offset;
    int unsigned   npages;
    logic [31:0]   page;
    page_run_t     r;
    npages = sb.active_pages();
    pick   = $urandom_range(99);
    c = make_cmd(FUNC_ALLOC, 0, $urandom, 1'($urandom_range(1)));
    if (pick < 42) begin
      c.run_pages = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(1, 64))
                                             : COUNT_W'($urandom_range(1, 8));
    end else if (pick < 47) begin
      c.run_pages = COUNT_W'($urandom_range(0, 2047));
    end else if (pick < 50) begin
      c.run_pages = '0;
    end else if (pick < 85 && sb.live.size() > 0) begin
      idx = $urandom_range(sb.live.size() - 1);
      r   = sb.live[idx];
      sb.live.delete(idx);
      c.func = FUNC_FREE;
      if ($urandom_range(4) == 0) begin
        offset      = $urandom_range(r.count - 1);
        c.address   = r.addr + (offset << PAGE_SHIFT) + $urandom_range(PAGE_BYTES - 1);
        c.run_pages = COUNT_W'($urandom_range(0, r.count - offset));
      end else begin
        c.address   = r.addr + $urandom_range(PAGE_BYTES - 1);
        c.run_pages = r.count;
      end
    end else begin
      c.func = FUNC_FREE;
      if ($urandom_range(1) == 0) begin
        page      = sb.pool_base + $urandom_range(0, npages + 4) - 2;
        c.address = {page[BASE_W-1:0], 12'($urandom_range(PAGE_BYTES - 1))};
      end
      c.run_pages = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(0, 2047))
                                             : COUNT_W'($urandom_range(0, 16));
    end
    return c;
  endfunction

  task automatic run_directed();
    logic [ADDR_W-1:0] b;
    b = ADDR_W'(sb.pool_base) << PAGE_SHIFT;
    send_command(make_cmd(FUNC_ALLOC, 0, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_ALLOC, 1, 32'hFFFF_FFFF, 1'b1), 0);
    send_command(make_cmd(FUNC_ALLOC, 3, '0, 1'b0), 0);
    send_command(make_cmd(FUNC_ALLOC, 1024, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_ALLOC, 2047, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_FREE, 1, b + 4095, 1'b0), 0);
    send_command(make_cmd(FUNC_ALLOC, 2, '0, 1'b0), 0);
    send_command(make_cmd(FUNC_ALLOC, 1, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_FREE, 0, b + 8 * PAGE_BYTES, 1'b1), 0);
    send_command(make_cmd(FUNC_FREE, 1, b - 1, 1'b0), 0);
    send_command(make_cmd(FUNC_FREE, 1, b + 1024 * PAGE_BYTES, 1'b0), 0);
    send_command(make_cmd(FUNC_FREE, 5, b + 1020 * PAGE_BYTES, 1'b0), 0);
    send_command(make_cmd(FUNC_FREE, 4, b + 1020 * PAGE_BYTES, 1'b0), 0);
    send_command(make_cmd(FUNC_FREE, 2047, 32'hFFFF_FFFF, 1'b1), 0);
    send_command(make_cmd(FUNC_FREE, 1024, b, 1'b0), 0);
    send_command(make_cmd(FUNC_ALLOC, 1024, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_ALLOC, 1, '0, 1'b0), 0);
    send_command(make_cmd(FUNC_FREE, 512, b + 512 * PAGE_BYTES, 1'b0), 0);
    send_command(make_cmd(FUNC_ALLOC, 513, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_ALLOC, 512, '0, 1'b1), 0);
    send_command(make_cmd(FUNC_FREE, 0, '0, 1'b0), 0);
    send_command(make_cmd(FUNC_FREE, 1024, b, 1'b1), 0);
    sb.live.delete();
  endtask

  initial begin
    int unsigned seg_pages[NUM_SEGS];
    int unsigned seg_base[NUM_SEGS];
    int unsigned seg_items[NUM_SEGS];
    int unsigned seg_gap[NUM_SEGS];
    seg_pages = '{1024, 1, 2047, 0, $urandom_range(2, 1023), 1024};
    seg_base  = '{256, 0, 20'hFFFFF, $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF), 0};
    seg_items = '{245, 110, 245, 40, 240, 240};
    seg_gap   = '{11, 11, 46, 46, 0, 0};
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg_idle(CFG_POOL_PAGES, {9'h1A5, 11'd1024});
    write_reg_idle(CFG_POOL_BASE_PAGE, 20'd256);
    run_directed();

    for (int s = 0; s < NUM_SEGS; s++) begin
      start <= 1'b0;
      write_reg_idle(CFG_POOL_PAGES, {9'($urandom), 11'(seg_pages[s])});
      write_reg_idle(CFG_POOL_BASE_PAGE, seg_base[s][CFG_DATA_W-1:0]);
      for (int n = 0; n < seg_items[s]; n++) send_command(random_cmd(), seg_gap[s]);
      release_pool(seg_gap[s]);
    end

    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d commands and %0d register writes across %0d pool settings.",
             sb.commands, sb.cfg_writes, NUM_SEGS + 1);
    $display("Outcomes: %0d allocated, %0d freed, %0d zero count, %0d out of memory, %0d ignored.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_map_ram.sv
sv/bitmap_page_allocator_core.sv
sim/bitmap_page_allocator_core_tb.sv
